[rtl/cst_pkg.sv]
package cst_pkg;

   // default sizing of the table
   localparam int CAPACITY_DEF = 128;
   localparam int KEY_BITS_DEF = 32;

   // field widths on the ports
   localparam int OP_W = 2;
   localparam int KEY_W = 32;
   localparam int STATUS_W = 3;
   localparam int SLOT_W = 7;
   localparam int USED_W = 8;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;

   // operation codes
   localparam logic [OP_W-1:0] OP_ADD = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_ADDED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FOUND = 3'd5;

   // source of the reported slot
   localparam logic [1:0] SLOT_ZERO = 2'd0;
   localparam logic [1:0] SLOT_INDEX = 2'd1;
   localparam logic [1:0] SLOT_COUNT = 2'd2;

   // commands from controller to datapath
   typedef struct packed {
      logic                capture;
      logic                apply;
      logic                append;
      logic                remove;
      logic [STATUS_W-1:0] status;
      logic [1:0]          slot_sel;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic            found;
      logic            full;
      logic [OP_W-1:0] op;
   } stat_type;

endpackage

[rtl/cst_ctrl.sv]
module cst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  cst_pkg::stat_type stat,
   output cst_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE  = 2'b01,
      S_APPLY = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      out_blocked;

   // a result still waiting holds back the update
   assign out_blocked = rsp_tvalid_ff && !rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      cmd = '0;
      cmd.status = cst_pkg::ST_NOTFOUND;
      cmd.slot_sel = cst_pkg::SLOT_ZERO;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (!out_blocked) begin
               cmd.apply = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in = S_IDLE;
               case (stat.op)
                  cst_pkg::OP_ADD: begin
                     if (stat.found) begin
                        cmd.status = cst_pkg::ST_PRESENT;
                        cmd.slot_sel = cst_pkg::SLOT_INDEX;
                     end else if (stat.full) begin
                        cmd.status = cst_pkg::ST_FULL;
                     end else begin
                        cmd.status = cst_pkg::ST_ADDED;
                        cmd.slot_sel = cst_pkg::SLOT_COUNT;
                        cmd.append = 1'b1;
                     end
                  end
                  cst_pkg::OP_DELETE: begin
                     if (stat.found) begin
                        cmd.status = cst_pkg::ST_REMOVED;
                        cmd.slot_sel = cst_pkg::SLOT_INDEX;
                        cmd.remove = 1'b1;
                     end
                  end
                  cst_pkg::OP_FIND: begin
                     if (stat.found) begin
                        cmd.status = cst_pkg::ST_FOUND;
                        cmd.slot_sel = cst_pkg::SLOT_INDEX;
                     end
                  end
                  default: begin
                     cmd.status = cst_pkg::ST_NOTFOUND;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

`ifndef SYNTHESIS
   // an accepted transaction moves to the apply state
   a_capture_then_apply: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == S_APPLY)
      else $error("capture not followed by apply state");

   // an applied request always leaves a response behind
   a_apply_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> rsp_tvalid_ff)
      else $error("applied request produced no response");

   // append never happens on a full table or together with a remove
   a_append_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> (!stat.full && !cmd.remove))
      else $error("illegal append");
`endif

endmodule

[rtl/cst_datapath.sv]
module cst_datapath #(
   parameter int CAPACITY = cst_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = cst_pkg::KEY_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [cst_pkg::OP_W-1:0]       req_op,
   input  logic [cst_pkg::KEY_W-1:0]      req_key,
   input  cst_pkg::cmd_type               cmd,
   output cst_pkg::stat_type              stat,
   output logic [cst_pkg::STATUS_W-1:0]   rsp_status,
   output logic [cst_pkg::SLOT_W-1:0]     rsp_slot,
   output logic [cst_pkg::USED_W-1:0]     rsp_entries_used
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic [KEY_BITS-1:0]         key_ext;
   logic [KEY_BITS-1:0]         key_cell_ff [CAPACITY];
   logic [KEY_BITS-1:0]         key_ff;
   logic [cst_pkg::OP_W-1:0]    op_ff;
   logic [CAPACITY-1:0]         match_ff;
   logic [CW-1:0]               count_ff, count_in;
   logic [IW-1:0]               hit_idx;
   logic [IW-1:0]               slot_pick;
   logic [cst_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [cst_pkg::SLOT_W-1:0]  rsp_slot_ff;
   logic [cst_pkg::USED_W-1:0]  rsp_used_ff;

   // only the low KEY_BITS key bits take part; a wider KEY_BITS zero-extends the key
   generate
      if (KEY_BITS <= cst_pkg::KEY_W) begin : g_key_narrow
         assign key_ext = req_key[KEY_BITS-1:0];
      end else begin : g_key_wide
         assign key_ext = {{(KEY_BITS - cst_pkg::KEY_W){1'b0}}, req_key};
      end
   endgenerate

   // parallel compare of every used cell at accept time
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_op;
         key_ff <= key_ext;
         for (int j = 0; j < CAPACITY; j++) begin
            match_ff[j] <= (CW'(j) < count_ff) && (key_cell_ff[j] == key_ext);
         end
      end
   end

   // keys are distinct, so at most one match: or-encode its index
   always_comb begin
      hit_idx = '0;
      for (int j = 0; j < CAPACITY; j++) begin
         if (match_ff[j]) begin
            hit_idx = hit_idx | IW'(j);
         end
      end
   end

   assign stat.found = |match_ff;
   assign stat.full = (count_ff == CW'(CAPACITY));
   assign stat.op = op_ff;

   // cells: shift down above the removed index, or take the appended key
   generate
      for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
         if (j < CAPACITY - 1) begin : g_shift
            always_ff @(posedge clock) begin
               if (cmd.apply && cmd.remove && (hit_idx <= IW'(j))) begin
                  key_cell_ff[j] <= key_cell_ff[j+1];
               end else if (cmd.apply && cmd.append && (count_ff == CW'(j))) begin
                  key_cell_ff[j] <= key_ff;
               end
            end
         end else begin : g_top
            always_ff @(posedge clock) begin
               if (cmd.apply && cmd.append && (count_ff == CW'(j))) begin
                  key_cell_ff[j] <= key_ff;
               end
            end
         end
      end
   endgenerate

   // entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.apply && cmd.append) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.apply && cmd.remove) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // slot source
   always_comb begin
      case (cmd.slot_sel)
         cst_pkg::SLOT_INDEX: slot_pick = hit_idx;
         cst_pkg::SLOT_COUNT: slot_pick = IW'(count_ff);
         default:             slot_pick = '0;
      endcase
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_status_ff <= cmd.status;
         rsp_slot_ff <= cst_pkg::SLOT_W'(slot_pick);
         rsp_used_ff <= cst_pkg::USED_W'(count_in);
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_slot = rsp_slot_ff;
   assign rsp_entries_used = rsp_used_ff;

`ifndef SYNTHESIS
   // stored keys stay distinct, so a compare hits at most one cell
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.capture) |-> $onehot0(match_ff))
      else $error("key matched more than one cell");

   // count never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");
`endif

endmodule

[rtl/compacting_set_table.sv]
// Set of distinct keys held in a dense table of CAPACITY cells plus an entry
// count. A request (op add, delete or find, and a key) gives exactly one
// response with a status, the key's slot and the entry count afterwards.
// When a request is accepted its key is compared against every used cell at
// once and the matches are registered; in the update state the single match is
// encoded to its slot and the table is updated (append at the count, or all
// cells above a deleted slot shift down one place in the same cycle). The
// response sits in an output register, and the next request is taken while
// it waits; the update cycle only stalls when a previous response is still
// unread. Op code 3 reports not found and changes nothing. Cells need no
// clearing after reset, so the block is ready right away.
module compacting_set_table #(
   parameter int CAPACITY = cst_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = cst_pkg::KEY_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // op [1:0], key [33:2], zero [39:34]
   input  logic [cst_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status [2:0], slot [9:3], entries_used [17:10], zero [23:18]
   output logic [cst_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   cst_pkg::cmd_type              cmd;
   cst_pkg::stat_type             stat;
   logic [cst_pkg::STATUS_W-1:0]  rsp_status;
   logic [cst_pkg::SLOT_W-1:0]    rsp_slot;
   logic [cst_pkg::USED_W-1:0]    rsp_entries_used;

   // controller
   cst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // key cells, match and response payload
   cst_datapath #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_tdata[1:0]),
      .req_key          (req_tdata[33:2]),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_entries_used (rsp_entries_used)
   );

   // pack the response
   assign rsp_tdata = {6'd0, rsp_entries_used, rsp_slot, rsp_status};

endmodule
